// ----- sv/assert_macros.svh -----
// Assertion macros shared by the profiler RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("same-cycle implication failed");
// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/hspu_pkg.sv -----
// Shared types and constants of the hierarchical section profiler.
// Depends on nothing.
package hspu_pkg;

	// Default sizes.
	localparam int unsigned SLOT_COUNT_DEF = 64;
	localparam int unsigned ID_BITS_DEF    = 8;
	localparam int unsigned TIME_BITS_DEF  = 32;

	// Weight arithmetic in Q1.16.
	localparam int unsigned W_BITS     = 17;
	localparam int unsigned FRAC_BITS  = 16;
	localparam logic [16:0] W_ONE      = 17'd65536;
	localparam logic [16:0] W_FACTOR   = 17'd52429;
	localparam int unsigned ROUND_HALF = 32768;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_BEGIN,
		REQ_END,
		REQ_FRAME,
		REQ_NONE
	} req_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STS_OK,
		STS_FULL,
		STS_UNMATCHED,
		STS_REPORT,
		STS_OPEN,
		STS_OVER,
		STS_HFULL
	} status_t;

	// History blend steps.
	typedef enum logic [1:0] {
		BL_AVG,
		BL_MIN,
		BL_MAX
	} blend_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_EV,
		ST_BEG_WR,
		ST_END_DEC,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_PAR_RD,
		ST_PAR_EV,
		ST_SELF_RD,
		ST_SELF_EV,
		ST_WGT,
		ST_WGT_W,
		ST_FR_RD,
		ST_FR_EV,
		ST_H_RD,
		ST_H_EV,
		ST_BL_GO,
		ST_BL_WAIT,
		ST_H_WR,
		ST_EMIT
	} state_t;

endpackage

// ----- sv/hspu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hspu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/hspu_mul.sv -----
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on nothing; shared by the weight and blend steps of the profiler.
module hspu_mul #(
	parameter int unsigned A_BITS = 32,
	parameter int unsigned B_BITS = 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [A_BITS-1:0]        a,
	input  logic [B_BITS-1:0]        b,
	output logic                     done,
	output logic [A_BITS+B_BITS-1:0] prod
);

	localparam int unsigned PW   = A_BITS + B_BITS;
	localparam int unsigned CNTW = $clog2(B_BITS + 1);

	logic [CNTW-1:0]   cnt_q;
	logic              done_q;
	logic [PW-1:0]     acc_q;
	logic [PW-1:0]     mc_q;
	logic [B_BITS-1:0] mp_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(B_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNTW'(1);
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// One conditional add of the shifted multiplicand per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= PW'(a);
			mp_q  <= b;
		end else if (cnt_q != '0) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- sv/hierarchical_section_profiler_unit.sv -----
// Top level of the hierarchical section profiler: sequencer, slot and history stores.
// Depends on hspu_pkg, hspu_ram, hspu_mul and assert_macros.svh.
//
//   channel  direction  fields
//   in       input      req_type, section_id, timestamp, frame_elapsed
//   out      output     status, report_id, call_count, nest_depth, *_ticks, last
//
// One item is handled at a time; in_stall is high from acceptance until the sequencer
// returns to idle. With n valid slots and h history entries, the time a begin or an end
// takes grows with n, and the time a frame end takes grows with n and h,
// set by the single-read slot and history stores and the shift-and-add multiplier.
// No clearing pass is needed after reset. A stalled result holds the sequencer.
`include "assert_macros.svh"
module hierarchical_section_profiler_unit #(
	parameter int unsigned SLOT_COUNT = hspu_pkg::SLOT_COUNT_DEF,
	parameter int unsigned ID_BITS    = hspu_pkg::ID_BITS_DEF,
	parameter int unsigned TIME_BITS  = hspu_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  section_id,
	input  logic [31:0] timestamp,
	input  logic [31:0] frame_elapsed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  report_id,
	output logic [31:0] call_count,
	output logic [6:0]  nest_depth,
	output logic [31:0] average_ticks,
	output logic [31:0] minimum_ticks,
	output logic [31:0] maximum_ticks,
	output logic        last
);

	import hspu_pkg::*;

	localparam int unsigned IW  = $clog2(SLOT_COUNT);
	localparam int unsigned CW  = $clog2(SLOT_COUNT + 1);
	localparam int unsigned IDW = ID_BITS;
	localparam int unsigned TW  = TIME_BITS;
	localparam int unsigned AW  = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int unsigned PW  = AW + W_BITS;
	localparam int unsigned SRW = IDW + 8 + 32 + 3 * TW + 7;
	localparam int unsigned HRW = IDW + 3 * TW;

	state_t state_q, state_d;

	// Control state.
	logic [CW-1:0] slot_fill_q, hist_fill_q;

	// Item and working registers.
	req_t           req_q;
	logic [IDW-1:0] id_q;
	logic [TW-1:0]  now_q;
	logic [31:0]    fel_q;
	logic [CW-1:0]  idx_q, hidx_q;
	logic [IW-1:0]  sel_q, par_q, hsel_q;
	logic [IDW-1:0] cur_tag_q;
	logic [7:0]     cur_open_q;
	logic [31:0]    cur_begin_q;
	logic [TW-1:0]  cur_start_q, cur_total_q, cur_child_q;
	logic [6:0]     cur_parent_q;
	logic [TW-1:0]  el_q, par_start_q;
	logic [6:0]     depth_q;
	logic           par_found_q;
	logic [16:0]    w_q;
	logic [TW-1:0]  self_q, d_q, h_avg_q, h_min_q, h_max_q;
	blend_t         k_q;

	// Result register.
	status_t        o_status_q;
	logic [7:0]     o_id_q;
	logic [31:0]    o_calls_q;
	logic [6:0]     o_depth_q;
	logic [31:0]    o_avg_q, o_min_q, o_max_q;
	logic           o_last_q;

	// Store ports.
	logic           slot_we, hist_we;
	logic [IW-1:0]  slot_waddr, slot_raddr, hist_waddr, hist_raddr;
	logic [SRW-1:0] slot_wdata, slot_rdata;
	logic [HRW-1:0] hist_wdata, hist_rdata;

	logic [IDW-1:0] rd_tag;
	logic [7:0]     rd_open;
	logic [31:0]    rd_begin;
	logic [TW-1:0]  rd_start, rd_total, rd_child;
	logic [6:0]     rd_parent;
	logic [IDW-1:0] hr_tag;
	logic [TW-1:0]  hr_avg, hr_min, hr_max;

	// Multiplier.
	logic           mul_start, mul_done;
	logic [AW-1:0]  mul_a;
	logic [16:0]    mul_b;
	logic [PW-1:0]  mul_prod;

	// Derived values.
	logic           idx_end, hidx_end, slots_room, hist_room, rd_is_open, item_last;
	logic [31:0]    begin_inc;
	logic [TW:0]    child_sum, total_sum;
	logic [TW-1:0]  child_new, total_new, self_new;
	logic [TW-1:0]  bl_a, bl_d, bl_t, bl_res;
	logic           bl_skip;
	logic [PW-1:0]  rnd_prod;
	logic [16:0]    w_new;
	status_t        frame_sts;

	assign {rd_tag, rd_open, rd_begin, rd_start, rd_total, rd_child, rd_parent} = slot_rdata;
	assign {hr_tag, hr_avg, hr_min, hr_max} = hist_rdata;

	hspu_ram #(.WIDTH(SRW), .DEPTH(SLOT_COUNT)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	hspu_ram #(.WIDTH(HRW), .DEPTH(SLOT_COUNT)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	hspu_mul #(.A_BITS(AW), .B_BITS(W_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Scan limits and flags.
	assign idx_end    = (idx_q == slot_fill_q);
	assign hidx_end   = (hidx_q == hist_fill_q);
	assign slots_room = (slot_fill_q != CW'(SLOT_COUNT));
	assign hist_room  = (hist_fill_q != CW'(SLOT_COUNT));
	assign rd_is_open = !rd_open[7] && (rd_open != 8'd0);
	assign item_last  = ((idx_q + CW'(1)) == slot_fill_q);
	assign begin_inc  = (cur_begin_q == 32'hFFFF_FFFF) ? cur_begin_q : cur_begin_q + 32'd1;

	// Saturating tick sums and self time.
	assign child_sum = {1'b0, rd_child} + {1'b0, el_q};
	assign total_sum = {1'b0, rd_total} + {1'b0, el_q};
	assign child_new = child_sum[TW] ? '1 : child_sum[TW-1:0];
	assign total_new = total_sum[TW] ? '1 : total_sum[TW-1:0];
	assign self_new  = (rd_total > rd_child) ? rd_total - rd_child : '0;

	// Blend operand selection and rounding of the product.
	always_comb begin
		unique case (k_q)
			BL_AVG:  bl_a = h_avg_q;
			BL_MIN:  bl_a = h_min_q;
			BL_MAX:  bl_a = h_max_q;
			default: bl_a = h_avg_q;
		endcase
	end

	assign bl_skip  = ((k_q == BL_MIN) && (self_q < h_min_q)) ||
	                  ((k_q == BL_MAX) && (self_q > h_max_q));
	assign bl_d     = (self_q >= bl_a) ? self_q - bl_a : bl_a - self_q;
	assign rnd_prod = (mul_prod + PW'(ROUND_HALF)) >> FRAC_BITS;
	assign bl_t     = (rnd_prod > PW'(d_q)) ? d_q : rnd_prod[TW-1:0];
	assign bl_res   = (self_q >= bl_a) ? bl_a + bl_t : bl_a - bl_t;
	assign w_new    = (rnd_prod > PW'(W_ONE)) ? W_ONE : rnd_prod[16:0];

	assign frame_sts = cur_open_q[7] ? STS_OVER : ((cur_open_q != 8'd0) ? STS_OPEN : STS_REPORT);

	assign mul_a     = (state_q == ST_WGT) ? AW'(fel_q) : AW'(bl_d);
	assign mul_b     = (state_q == ST_WGT) ? W_FACTOR : w_q;
	assign mul_start = (state_q == ST_WGT) || ((state_q == ST_BL_GO) && !bl_skip);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (req_t'(req_type))
						REQ_BEGIN, REQ_END: state_d = ST_FIND_RD;
						REQ_FRAME:          state_d = ST_WGT;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_FIND_RD: state_d = idx_end ? ST_EMIT : ST_FIND_EV;
			ST_FIND_EV: begin
				if (rd_tag == id_q) begin
					state_d = (req_q == REQ_BEGIN) ? ST_BEG_WR : ST_END_DEC;
				end else begin
					state_d = ST_FIND_RD;
				end
			end
			ST_BEG_WR:  state_d = ST_EMIT;
			ST_END_DEC: state_d = ST_SCAN_RD;
			ST_SCAN_RD: state_d = idx_end ? ST_PAR_RD : ST_SCAN_EV;
			ST_SCAN_EV: state_d = ST_SCAN_RD;
			ST_PAR_RD:  state_d = par_found_q ? ST_PAR_EV : ST_SELF_RD;
			ST_PAR_EV:  state_d = ST_SELF_RD;
			ST_SELF_RD: state_d = ST_SELF_EV;
			ST_SELF_EV: state_d = ST_EMIT;
			ST_WGT:     state_d = ST_WGT_W;
			ST_WGT_W:   state_d = mul_done ? ST_FR_RD : ST_WGT_W;
			ST_FR_RD:   state_d = idx_end ? ST_IDLE : ST_FR_EV;
			ST_FR_EV:   state_d = ST_H_RD;
			ST_H_RD:    state_d = hidx_end ? ST_EMIT : ST_H_EV;
			ST_H_EV:    state_d = (hr_tag == cur_tag_q) ? ST_BL_GO : ST_H_RD;
			ST_BL_GO: begin
				if (bl_skip) begin
					state_d = (k_q == BL_MAX) ? ST_H_WR : ST_BL_GO;
				end else begin
					state_d = ST_BL_WAIT;
				end
			end
			ST_BL_WAIT: begin
				if (mul_done) begin
					state_d = (k_q == BL_MAX) ? ST_H_WR : ST_BL_GO;
				end
			end
			ST_H_WR:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_stall) begin
					state_d = (req_q == REQ_FRAME) ? ST_FR_RD : ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Store control outputs.
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = sel_q;
		slot_wdata = {cur_tag_q, cur_open_q, cur_begin_q, cur_start_q, cur_total_q,
		              cur_child_q, cur_parent_q};
		slot_raddr = idx_q[IW-1:0];
		hist_we    = 1'b0;
		hist_waddr = hsel_q;
		hist_wdata = {cur_tag_q, h_avg_q, h_min_q, h_max_q};
		hist_raddr = hidx_q[IW-1:0];
		unique case (state_q)
			ST_FIND_RD: begin
				if (idx_end && (req_q == REQ_BEGIN) && slots_room) begin
					slot_we    = 1'b1;
					slot_waddr = slot_fill_q[IW-1:0];
					slot_wdata = {id_q, 8'd1, 32'd1, now_q, {TW{1'b0}}, {TW{1'b0}}, 7'd0};
				end
			end
			ST_BEG_WR: begin
				slot_we    = 1'b1;
				slot_wdata = {cur_tag_q, cur_open_q + 8'd1, begin_inc, now_q, cur_total_q,
				              cur_child_q, cur_parent_q};
			end
			ST_END_DEC: begin
				slot_we    = 1'b1;
				slot_wdata = {cur_tag_q, cur_open_q - 8'd1, cur_begin_q, cur_start_q,
				              cur_total_q, cur_child_q, cur_parent_q};
			end
			ST_PAR_RD:  slot_raddr = par_q;
			ST_PAR_EV: begin
				slot_we    = 1'b1;
				slot_waddr = par_q;
				slot_wdata = {rd_tag, rd_open, rd_begin, rd_start, rd_total, child_new,
				              rd_parent};
			end
			ST_SELF_RD: slot_raddr = sel_q;
			ST_SELF_EV: begin
				slot_we    = 1'b1;
				slot_wdata = {rd_tag, rd_open, rd_begin, rd_start, total_new, rd_child,
				              depth_q};
			end
			ST_H_RD: begin
				if (hidx_end && hist_room) begin
					hist_we    = 1'b1;
					hist_waddr = hist_fill_q[IW-1:0];
					hist_wdata = {cur_tag_q, self_q, self_q, self_q};
				end
			end
			ST_H_WR:    hist_we = 1'b1;
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_fill_q <= '0;
			hist_fill_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_FIND_RD) && idx_end && (req_q == REQ_BEGIN) && slots_room) begin
				slot_fill_q <= slot_fill_q + CW'(1);
			end else if ((state_q == ST_FR_RD) && idx_end) begin
				slot_fill_q <= '0;
			end
			if ((state_q == ST_H_RD) && hidx_end && hist_room) begin
				hist_fill_q <= hist_fill_q + CW'(1);
			end
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_q <= req_t'(req_type);
					id_q  <= IDW'(section_id);
					now_q <= TW'(timestamp);
					fel_q <= frame_elapsed;
					idx_q <= '0;
				end
			end
			ST_FIND_RD: begin
				if (idx_end) begin
					o_id_q    <= 8'(id_q);
					o_depth_q <= 7'd0;
					o_avg_q   <= '0;
					o_min_q   <= '0;
					o_max_q   <= '0;
					o_last_q  <= 1'b1;
					if (req_q == REQ_BEGIN && slots_room) begin
						o_status_q <= STS_OK;
						o_calls_q  <= 32'd1;
					end else begin
						o_status_q <= (req_q == REQ_BEGIN) ? STS_FULL : STS_UNMATCHED;
						o_calls_q  <= 32'd0;
					end
				end
			end
			ST_FIND_EV: begin
				if (rd_tag == id_q) begin
					sel_q        <= idx_q[IW-1:0];
					cur_tag_q    <= rd_tag;
					cur_open_q   <= rd_open;
					cur_begin_q  <= rd_begin;
					cur_start_q  <= rd_start;
					cur_total_q  <= rd_total;
					cur_child_q  <= rd_child;
					cur_parent_q <= rd_parent;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_BEG_WR: begin
				o_status_q <= STS_OK;
				o_id_q     <= 8'(cur_tag_q);
				o_calls_q  <= begin_inc;
				o_depth_q  <= cur_parent_q;
				o_avg_q    <= '0;
				o_min_q    <= '0;
				o_max_q    <= '0;
				o_last_q   <= 1'b1;
			end
			ST_END_DEC: begin
				el_q        <= now_q - cur_start_q;
				idx_q       <= '0;
				depth_q     <= 7'd0;
				par_found_q <= 1'b0;
			end
			ST_SCAN_EV: begin
				if (rd_is_open) begin
					if (depth_q != 7'd127) begin
						depth_q <= depth_q + 7'd1;
					end
					if (!par_found_q || (rd_start >= par_start_q)) begin
						par_q       <= idx_q[IW-1:0];
						par_start_q <= rd_start;
						par_found_q <= 1'b1;
					end
				end
				idx_q <= idx_q + CW'(1);
			end
			ST_SELF_EV: begin
				o_status_q <= STS_OK;
				o_id_q     <= 8'(rd_tag);
				o_calls_q  <= rd_begin;
				o_depth_q  <= depth_q;
				o_avg_q    <= '0;
				o_min_q    <= '0;
				o_max_q    <= '0;
				o_last_q   <= 1'b1;
			end
			ST_WGT_W: begin
				if (mul_done) begin
					w_q   <= w_new;
					idx_q <= '0;
				end
			end
			ST_FR_EV: begin
				cur_tag_q    <= rd_tag;
				cur_open_q   <= rd_open;
				cur_begin_q  <= rd_begin;
				cur_parent_q <= rd_parent;
				self_q       <= self_new;
				hidx_q       <= '0;
			end
			ST_H_RD: begin
				if (hidx_end) begin
					o_id_q    <= 8'(cur_tag_q);
					o_calls_q <= cur_begin_q;
					o_depth_q <= cur_parent_q;
					o_last_q  <= item_last;
					if (hist_room) begin
						o_status_q <= frame_sts;
						o_avg_q    <= 32'(self_q);
						o_min_q    <= 32'(self_q);
						o_max_q    <= 32'(self_q);
					end else begin
						o_status_q <= STS_HFULL;
						o_avg_q    <= '0;
						o_min_q    <= '0;
						o_max_q    <= '0;
					end
				end
			end
			ST_H_EV: begin
				if (hr_tag == cur_tag_q) begin
					hsel_q  <= hidx_q[IW-1:0];
					h_avg_q <= hr_avg;
					h_min_q <= hr_min;
					h_max_q <= hr_max;
					k_q     <= BL_AVG;
				end else begin
					hidx_q <= hidx_q + CW'(1);
				end
			end
			ST_BL_GO: begin
				if (bl_skip) begin
					if (k_q == BL_MIN) begin
						h_min_q <= self_q;
						k_q     <= BL_MAX;
					end else begin
						h_max_q <= self_q;
					end
				end else begin
					d_q <= bl_d;
				end
			end
			ST_BL_WAIT: begin
				if (mul_done) begin
					unique case (k_q)
						BL_AVG: begin
							h_avg_q <= bl_res;
							k_q     <= BL_MIN;
						end
						BL_MIN: begin
							h_min_q <= bl_res;
							k_q     <= BL_MAX;
						end
						default: h_max_q <= bl_res;
					endcase
				end
			end
			ST_H_WR: begin
				o_status_q <= frame_sts;
				o_id_q     <= 8'(cur_tag_q);
				o_calls_q  <= cur_begin_q;
				o_depth_q  <= cur_parent_q;
				o_avg_q    <= 32'(h_avg_q);
				o_min_q    <= 32'(h_min_q);
				o_max_q    <= 32'(h_max_q);
				o_last_q   <= item_last;
			end
			ST_EMIT: begin
				if (!out_stall && (req_q == REQ_FRAME)) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Ports.
	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = (state_q == ST_EMIT);
	assign status        = o_status_q;
	assign report_id     = o_id_q;
	assign call_count    = o_calls_q;
	assign nest_depth    = o_depth_q;
	assign average_ticks = o_avg_q;
	assign minimum_ticks = o_min_q;
	assign maximum_ticks = o_max_q;
	assign last          = o_last_q;

	// Checks.
	`ASSERT_IMPLY(a_emit_busy, out_valid, in_stall)
	`ASSERT_IMPLY(a_fill_range, 1'b1, slot_fill_q <= CW'(SLOT_COUNT))
	`ASSERT_IMPLY(a_mul_ctx, mul_done, (state_q == ST_WGT_W) || (state_q == ST_BL_WAIT))
	`ASSERT_NEXT(a_hist_grow, 1'b1, hist_fill_q >= $past(hist_fill_q))

endmodule
